[src/fragment_reassembler_defines.svh]
// ----------------------------------------------------------------------------
// fragment_reassembler_defines.svh
// Assertion macros shared by the fragment reassembler modules.
// ----------------------------------------------------------------------------
`ifndef FRAGMENT_REASSEMBLER_DEFINES_SVH
`define FRAGMENT_REASSEMBLER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FRGR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FRGR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/frgr_pkg.sv]
// ----------------------------------------------------------------------------
// frgr_pkg
// Shared types and codes for the fragment reassembler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frgr_pkg;

  // Width used for length and index compares (buffer sizes up to 131071).
  localparam int CMP_W = 17;
  // Header bytes of an INIT fragment: command plus two length bytes.
  localparam logic [1:0] HDR_BYTES = 2'd3;

  typedef enum logic [1:0] {
    ACT_FRAG  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_PARAM      = 3'd1,
    ST_SEQ        = 3'd2,
    ST_LARGE      = 3'd3,
    ST_INCOMPLETE = 3'd4
  } status_t;

  // One input item.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       frag_first;
    logic       frag_last;
    logic [9:0] read_index;
  } in_item_t;

  // Status snapshot of one result, without the read data.
  typedef struct packed {
    status_t     status;
    logic        complete;
    logic [10:0] message_length;
    logic [10:0] received_length;
    logic [6:0]  next_seq;
  } res_t;

  // One result item.
  typedef struct packed {
    res_t       res;
    logic [7:0] read_data;
  } out_item_t;

endpackage

[src/frgr_in_if.sv]
// ----------------------------------------------------------------------------
// frgr_in_if
// Input channel: one fragment byte, read request or reset per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface frgr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic       frag_first;
  logic       frag_last;
  logic [9:0] read_index;

  modport source (
    output valid, action, data_byte, frag_first, frag_last, read_index,
    input  ready
  );

  modport sink (
    input  valid, action, data_byte, frag_first, frag_last, read_index,
    output ready
  );
endinterface

[src/frgr_out_if.sv]
// ----------------------------------------------------------------------------
// frgr_out_if
// Result channel: status snapshot and read data per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface frgr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        complete;
  logic [10:0] message_length;
  logic [10:0] received_length;
  logic [6:0]  next_seq;
  logic [7:0]  read_data;

  modport source (
    output valid, status, complete, message_length, received_length, next_seq,
           read_data,
    input  ready
  );

  modport sink (
    input  valid, status, complete, message_length, received_length, next_seq,
           read_data,
    output ready
  );
endinterface

[src/fragment_reassembler.sv]
// ----------------------------------------------------------------------------
// fragment_reassembler
// Rebuilds a fragmented message from a byte stream into a buffer and reads
// it back byte by byte.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+----------------------------------------
//  in_ch    | in  | valid / ready    | action, data_byte, frag_first,
//           |     |                  | frag_last, read_index
//  out_ch   | out | valid / ready    | status, complete, message_length,
//           |     |                  | received_length, next_seq, read_data
//
//  One item per cycle while in_ch.ready is high; the state update and the
//  buffer write or read issue happen in the cycle of the transfer.
//  A result passes through a stage that waits on the buffer's registered
//  read port, then through the output register.
//  Reset (rst_n, synchronous) clears all message state; buffer contents are
//  not cleared and need no clearing pass.
//  in_ch.ready falls only while both result stages are full and out_ch is
//  stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fragment_reassembler #(
  parameter int MAX_MESSAGE_BYTES = 1024
) (
  input logic       clk,
  input logic       rst_n,
  frgr_in_if.sink   in_ch,
  frgr_out_if.source out_ch
);

  localparam int AW    = $clog2(MAX_MESSAGE_BYTES);
  localparam int LEN_W = $clog2(MAX_MESSAGE_BYTES + 1);

  logic                accept;
  frgr_pkg::in_item_t  item;
  logic                res_valid;
  frgr_pkg::res_t      res;
  logic                rd_ok;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [7:0]          wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [7:0]          mem_data;
  logic                in_ready;
  frgr_pkg::out_item_t out_item;

  // Input transfer
  assign accept          = in_ch.valid && in_ready;
  assign in_ch.ready     = in_ready;
  assign item.action     = in_ch.action;
  assign item.data_byte  = in_ch.data_byte;
  assign item.frag_first = in_ch.frag_first;
  assign item.frag_last  = in_ch.frag_last;
  assign item.read_index = in_ch.read_index;

  frgr_ctrl #(
    .MAX_BYTES (MAX_MESSAGE_BYTES),
    .AW        (AW),
    .LEN_W     (LEN_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (item),
    .res_valid (res_valid),
    .res       (res),
    .rd_ok     (rd_ok),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  frgr_store #(
    .DEPTH (MAX_MESSAGE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (mem_data)
  );

  frgr_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_res   (res),
    .push_rd_ok (rd_ok),
    .mem_data   (mem_data),
    .in_ready   (in_ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_item   (out_item)
  );

  // Result transfer
  assign out_ch.status          = out_item.res.status;
  assign out_ch.complete        = out_item.res.complete;
  assign out_ch.message_length  = out_item.res.message_length;
  assign out_ch.received_length = out_item.res.received_length;
  assign out_ch.next_seq        = out_item.res.next_seq;
  assign out_ch.read_data       = out_item.read_data;

endmodule

[src/frgr_store.sv]
// ----------------------------------------------------------------------------
// frgr_store
// Message buffer: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frgr_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/frgr_ctrl.sv]
// ----------------------------------------------------------------------------
// frgr_ctrl
// Reassembly state: header parsing, sequence check, buffer write and read
// requests, status snapshot for each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fragment_reassembler_defines.svh"

module frgr_ctrl #(
  parameter int MAX_BYTES = 1024,
  parameter int AW        = 10,
  parameter int LEN_W     = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  frgr_pkg::in_item_t item,
  output logic               res_valid,
  output frgr_pkg::res_t     res,
  output logic               rd_ok,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [7:0]         wr_data,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr
);

  localparam logic [frgr_pkg::CMP_W-1:0] MAX_C = frgr_pkg::CMP_W'(MAX_BYTES);

  logic [LEN_W-1:0]  total_r, total_nxt;
  logic [LEN_W-1:0]  stored_r, stored_nxt;
  logic [6:0]        seq_r, seq_nxt;
  logic              inprog_r, inprog_nxt;
  logic [1:0]        bpos_r, bpos_nxt;
  logic              finit_r, finit_nxt;
  frgr_pkg::status_t ferr_r, ferr_nxt;
  logic [7:0]        lenhi_r, lenhi_nxt;

  logic [frgr_pkg::CMP_W-1:0] idx_ext;
  logic [frgr_pkg::CMP_W-1:0] tot_ext;

  assign idx_ext = frgr_pkg::CMP_W'(item.read_index);
  assign tot_ext = frgr_pkg::CMP_W'(total_r);
  assign rd_addr = idx_ext[AW-1:0];
  assign wr_addr = stored_r[AW-1:0];
  assign wr_data = item.data_byte;

  // Next state, buffer requests and status code
  always_comb begin
    logic [1:0]        pos;
    frgr_pkg::status_t err;
    logic              init;
    logic [15:0]       tl;
    frgr_pkg::status_t st;

    total_nxt  = total_r;
    stored_nxt = stored_r;
    seq_nxt    = seq_r;
    inprog_nxt = inprog_r;
    bpos_nxt   = bpos_r;
    finit_nxt  = finit_r;
    ferr_nxt   = ferr_r;
    lenhi_nxt  = lenhi_r;
    res_valid  = 1'b0;
    rd_ok      = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    pos        = 2'd0;
    err        = frgr_pkg::ST_OK;
    init       = 1'b0;
    tl         = 16'd0;
    st         = frgr_pkg::ST_OK;

    if (accept) begin
      case (frgr_pkg::action_t'(item.action))
        frgr_pkg::ACT_FRAG: begin
          if (!item.frag_first && bpos_r == 2'd0) begin
            // stray byte outside any fragment
            if (item.frag_last) begin
              res_valid = 1'b1;
              st        = frgr_pkg::ST_PARAM;
            end
          end else begin
            pos  = item.frag_first ? 2'd0 : bpos_r;
            err  = item.frag_first ? frgr_pkg::ST_OK : ferr_r;
            init = item.frag_first ? item.data_byte[7] : finit_r;
            finit_nxt = init;
            if (pos == 2'd0) begin
              // command byte: CONT must match the expected sequence
              if (!init && (!inprog_r || item.data_byte[6:0] != seq_r)) begin
                err = frgr_pkg::ST_SEQ;
              end
            end else if (err == frgr_pkg::ST_OK) begin
              if (init && pos == 2'd1) begin
                lenhi_nxt = item.data_byte;
              end else if (init && pos == 2'd2) begin
                tl = {lenhi_r, item.data_byte};
                if (frgr_pkg::CMP_W'(tl) > MAX_C) begin
                  err = frgr_pkg::ST_LARGE;
                end else begin
                  total_nxt  = tl[LEN_W-1:0];
                  stored_nxt = '0;
                  seq_nxt    = 7'd0;
                  inprog_nxt = 1'b1;
                end
              end else if (stored_r < total_r) begin
                // payload, clamped to the announced length
                wr_en      = 1'b1;
                stored_nxt = stored_r + LEN_W'(1);
              end
            end
            bpos_nxt = (pos == frgr_pkg::HDR_BYTES) ? pos : pos + 2'd1;
            ferr_nxt = err;
            if (item.frag_last) begin
              if (err == frgr_pkg::ST_OK && init && pos < frgr_pkg::HDR_BYTES - 2'd1) begin
                err = frgr_pkg::ST_PARAM;
              end
              if (err == frgr_pkg::ST_OK) begin
                seq_nxt = seq_nxt + 7'd1;
              end
              st        = err;
              bpos_nxt  = 2'd0;
              ferr_nxt  = frgr_pkg::ST_OK;
              res_valid = 1'b1;
            end
          end
        end
        frgr_pkg::ACT_READ: begin
          res_valid = 1'b1;
          if (!(inprog_r && stored_r >= total_r)) begin
            st = frgr_pkg::ST_INCOMPLETE;
          end else if (idx_ext >= tot_ext || idx_ext >= MAX_C) begin
            st = frgr_pkg::ST_PARAM;
          end else begin
            rd_ok = 1'b1;
            rd_en = 1'b1;
          end
        end
        frgr_pkg::ACT_CLEAR: begin
          total_nxt  = '0;
          stored_nxt = '0;
          seq_nxt    = 7'd0;
          inprog_nxt = 1'b0;
          bpos_nxt   = 2'd0;
          finit_nxt  = 1'b0;
          ferr_nxt   = frgr_pkg::ST_OK;
          lenhi_nxt  = 8'd0;
          res_valid  = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // Snapshot taken from the state after this item
    res.status          = st;
    res.complete        = inprog_nxt && (stored_nxt >= total_nxt);
    res.message_length  = 11'(total_nxt);
    res.received_length = 11'(stored_nxt);
    res.next_seq        = seq_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      stored_r <= '0;
      seq_r    <= 7'd0;
      inprog_r <= 1'b0;
      bpos_r   <= 2'd0;
      finit_r  <= 1'b0;
      ferr_r   <= frgr_pkg::ST_OK;
      lenhi_r  <= 8'd0;
    end else begin
      total_r  <= total_nxt;
      stored_r <= stored_nxt;
      seq_r    <= seq_nxt;
      inprog_r <= inprog_nxt;
      bpos_r   <= bpos_nxt;
      finit_r  <= finit_nxt;
      ferr_r   <= ferr_nxt;
      lenhi_r  <= lenhi_nxt;
    end
  end

  // Checks
  `FRGR_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, stored_r <= total_r, "stored count passed total length")
  `FRGR_ASSERT_IMP(a_write_in_msg, clk, rst_n, wr_en, inprog_r && stored_r < total_r, "buffer write outside an open message")
  `FRGR_ASSERT_NXT(a_clear_idle, clk, rst_n, accept && item.action == frgr_pkg::ACT_CLEAR, !inprog_r && bpos_r == 2'd0 && stored_r == '0, "reset action left state behind")

endmodule

[src/frgr_out.sv]
// ----------------------------------------------------------------------------
// frgr_out
// Result path: a stage that waits for buffer read data, then the output
// register. Drives input ready from the state of the two stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fragment_reassembler_defines.svh"

module frgr_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  frgr_pkg::res_t      push_res,
  input  logic                push_rd_ok,
  input  logic [7:0]          mem_data,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output frgr_pkg::out_item_t out_item
);

  logic                s1_v_r, s1_v_nxt;
  frgr_pkg::res_t      s1_res_r;
  logic                s1_rd_ok_r;
  logic                s2_v_r, s2_v_nxt;
  frgr_pkg::out_item_t s2_r;
  logic                adv;

  // Stage 1 moves on when the output register is free or being emptied
  assign adv      = s1_v_r && (!s2_v_r || out_ready);
  assign in_ready = !s1_v_r || adv;

  always_comb begin
    s1_v_nxt = push ? 1'b1 : (adv ? 1'b0 : s1_v_r);
    s2_v_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : s2_v_r);
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // Payload, read data merged on the way to the output register
  always_ff @(posedge clk) begin
    if (push) begin
      s1_res_r   <= push_res;
      s1_rd_ok_r <= push_rd_ok;
    end
    if (adv) begin
      s2_r.res       <= s1_res_r;
      s2_r.read_data <= s1_rd_ok_r ? mem_data : 8'd0;
    end
  end

  assign out_valid = s2_v_r;
  assign out_item  = s2_r;

  // Checks
  `FRGR_ASSERT_IMP(a_no_overrun, clk, rst_n, push, !s1_v_r || adv, "result pushed into a full stage")
  `FRGR_ASSERT_NXT(a_stall_keeps, clk, rst_n, s1_v_r && s2_v_r && !out_ready, s1_v_r && s2_v_r, "result lost during stall")

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fragment_reassembler. Fragment streams, reads and
// resets go in through a queued driver with random gaps. A predictor keeps
// its own copy of the reassembly state and message buffer. Every result that
// comes out is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int MSG_MAX     = 1024;   // buffer size the block is built with
  localparam int STIM_ITEMS  = 1050;   // random stimulus target
  localparam int TAIL_ITEMS  = 100;    // no idling once this few remain
  localparam int HOLD_CYCLES = 80;     // long receiver hold-off
  localparam int HOLD_AFTER  = 300;    // transfers in before the hold-off
  localparam int STALL_LIMIT = 2000;   // cycles without any transfer

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst_n;

  frgr_in_if  in_ch ();
  frgr_out_if out_ch ();

  fragment_reassembler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // Stimulus waiting for the driver and predicted results waiting for the DUT
  frgr_pkg::in_item_t  pending_items[$];
  frgr_pkg::out_item_t expected_results[$];

  int stim_count;
  int total_items;
  int items_done;
  int results_seen;
  int error_statuses;
  int data_reads;
  int err_count;
  int stall_cycles;

  // Predictor state
  logic [7:0]        msg_buf [MSG_MAX];
  logic [10:0]       tot_len;
  logic [10:0]       got_len;
  logic [6:0]        seq_exp;
  logic              busy;
  logic [1:0]        frag_pos;
  logic              frag_init;
  frgr_pkg::status_t frag_err;
  logic [7:0]        len_hi;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic frgr_pkg::out_item_t snapshot(frgr_pkg::status_t st,
                                                   logic [7:0] rd);
    frgr_pkg::out_item_t r;
    r.res.status          = st;
    r.res.complete        = busy && (got_len >= tot_len);
    r.res.message_length  = tot_len;
    r.res.received_length = got_len;
    r.res.next_seq        = seq_exp;
    r.read_data           = rd;
    return r;
  endfunction

  function automatic void clear_reassembly();
    tot_len   = '0;
    got_len   = '0;
    seq_exp   = '0;
    busy      = 1'b0;
    frag_pos  = '0;
    frag_init = 1'b0;
    frag_err  = frgr_pkg::ST_OK;
    len_hi    = '0;
  endfunction

  // Applies one transfer to the state; returns 1 when it yields a result
  function automatic bit reassemble(input frgr_pkg::in_item_t it,
                                    output frgr_pkg::out_item_t rsp);
    logic [1:0]        pos;
    logic [15:0]       ann_len;
    frgr_pkg::status_t st;
    bit                has_rsp;
    has_rsp = 1'b0;
    rsp     = '0;
    case (frgr_pkg::action_t'(it.action))
      frgr_pkg::ACT_FRAG: begin
        if (it.frag_first) begin
          frag_pos  = '0;
          frag_err  = frgr_pkg::ST_OK;
          frag_init = it.data_byte[7];
        end
        if (!it.frag_first && frag_pos == 0) begin
          // stray byte outside a fragment
          if (it.frag_last) begin
            rsp     = snapshot(frgr_pkg::ST_PARAM, 8'h00);
            has_rsp = 1'b1;
          end
        end else begin
          pos = frag_pos;
          if (pos == 0) begin
            if (!frag_init && (!busy || it.data_byte[6:0] != seq_exp))
              frag_err = frgr_pkg::ST_SEQ;
          end else if (frag_err == frgr_pkg::ST_OK) begin
            if (frag_init && pos == 1) begin
              len_hi = it.data_byte;
            end else if (frag_init && pos == 2) begin
              // length commits on the third INIT byte
              ann_len = {len_hi, it.data_byte};
              if (ann_len > MSG_MAX) begin
                frag_err = frgr_pkg::ST_LARGE;
              end else begin
                tot_len = ann_len[10:0];
                got_len = '0;
                seq_exp = '0;
                busy    = 1'b1;
              end
            end else if (got_len < tot_len) begin
              // payload, clamped to the announced length
              msg_buf[got_len[9:0]] = it.data_byte;
              got_len++;
            end
          end
          if (frag_pos < frgr_pkg::HDR_BYTES) frag_pos++;
          if (it.frag_last) begin
            if (frag_err == frgr_pkg::ST_OK && frag_init &&
                pos < frgr_pkg::HDR_BYTES - 2'd1)
              frag_err = frgr_pkg::ST_PARAM;
            st = frag_err;
            if (st == frgr_pkg::ST_OK) seq_exp++;
            frag_pos = '0;
            frag_err = frgr_pkg::ST_OK;
            rsp      = snapshot(st, 8'h00);
            has_rsp  = 1'b1;
          end
        end
      end
      frgr_pkg::ACT_READ: begin
        if (!(busy && got_len >= tot_len))
          rsp = snapshot(frgr_pkg::ST_INCOMPLETE, 8'h00);
        else if ({1'b0, it.read_index} >= tot_len)
          rsp = snapshot(frgr_pkg::ST_PARAM, 8'h00);
        else
          rsp = snapshot(frgr_pkg::ST_OK, msg_buf[it.read_index]);
        has_rsp = 1'b1;
      end
      frgr_pkg::ACT_CLEAR: begin
        clear_reassembly();
        rsp     = snapshot(frgr_pkg::ST_OK, 8'h00);
        has_rsp = 1'b1;
      end
      default: ;
    endcase
    return has_rsp;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic queue_item(frgr_pkg::action_t a, logic [7:0] b, logic f,
                            logic l, logic [9:0] idx);
    frgr_pkg::in_item_t it;
    it.action     = a;
    it.data_byte  = b;
    it.frag_first = f;
    it.frag_last  = l;
    it.read_index = idx;
    pending_items.push_back(it);
    if (a != frgr_pkg::ACT_NOP) stim_count++;
  endtask

  // One fragment; close=0 leaves it open so the next one abandons it
  task automatic queue_fragment(byte_q_t bytes, bit close);
    for (int i = 0; i < bytes.size(); i++)
      queue_item(frgr_pkg::ACT_FRAG, bytes[i], i == 0,
                 close && (i == bytes.size() - 1), 10'($urandom));
  endtask

  task automatic queue_read(logic [9:0] idx);
    queue_item(frgr_pkg::ACT_READ, 8'($urandom), 1'($urandom), 1'($urandom),
               idx);
  endtask

  task automatic queue_clear();
    queue_item(frgr_pkg::ACT_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom),
               10'($urandom));
  endtask

  task automatic queue_noise(int unsigned n);
    repeat (n)
      queue_item(frgr_pkg::action_t'($urandom_range(0, 3)), 8'($urandom),
                 1'($urandom), 1'($urandom), 10'($urandom));
  endtask

  // INIT plus CONT fragments with random payload, some faults mixed in,
  // then a few reads. partial stops after two CONT fragments.
  task automatic queue_message(int unsigned len, int unsigned chunk, bit partial);
    byte_q_t     frag;
    int unsigned left;
    int unsigned n;
    int unsigned frags;
    logic [6:0]  seq;
    left = len;
    seq  = 7'd1;
    frag = {};
    frag.push_back(8'h80 | 8'($urandom_range(0, 127)));
    frag.push_back(8'(len >> 8));
    frag.push_back(8'(len));
    n = $urandom_range(0, chunk);
    if (n > left) n = left;
    repeat (n) frag.push_back(8'($urandom));
    left -= n;
    queue_fragment(frag, 1'b1);
    frags = 0;
    while (left > 0 && !(partial && frags == 2)) begin
      frag = {};
      n = $urandom_range(1, chunk);
      if (n > left) n = left;
      case ($urandom_range(0, 19))
        0: begin
          // wrong sequence number: fragment fails, nothing stored
          frag.push_back({1'b0, seq ^ 7'(1 << $urandom_range(0, 6))});
          repeat (n) frag.push_back(8'($urandom));
          queue_fragment(frag, 1'b1);
        end
        1: begin
          // left open: bytes stay, sequence does not advance
          frag.push_back({1'b0, seq});
          repeat (n) frag.push_back(8'($urandom));
          queue_fragment(frag, 1'b0);
          left -= n;
        end
        default: begin
          frag.push_back({1'b0, seq});
          repeat (n) frag.push_back(8'($urandom));
          // occasional overrun past the announced length
          if (n == left && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) frag.push_back(8'($urandom));
          queue_fragment(frag, 1'b1);
          seq++;
          left -= n;
        end
      endcase
      frags++;
    end
    repeat ($urandom_range(1, 3)) begin
      if (len > 0 && $urandom_range(0, 3) != 0)
        queue_read(10'($urandom_range(0, len - 1)));
      else
        queue_read(10'($urandom_range(0, 1023)));
    end
  endtask

  task automatic queue_broken();
    byte_q_t frag;
    frag = {};
    case ($urandom_range(0, 2))
      0: begin
        // INIT ending inside its header
        frag.push_back(8'h80 | 8'($urandom_range(0, 127)));
        if ($urandom_range(0, 1) == 1) frag.push_back(8'($urandom));
      end
      1: begin
        // announced length beyond the buffer
        frag.push_back(8'h80 | 8'($urandom_range(0, 127)));
        frag.push_back(8'($urandom_range(MSG_MAX + 1, 65535) >> 8));
        frag.push_back(8'($urandom));
        if (frag[1] == 8'h04) frag[2] = 8'h01 | frag[2];
        repeat ($urandom_range(0, 3)) frag.push_back(8'($urandom));
      end
      default: begin
        // CONT with an arbitrary sequence number
        frag.push_back(8'($urandom_range(0, 127)));
        repeat ($urandom_range(0, 4)) frag.push_back(8'($urandom));
      end
    endcase
    queue_fragment(frag, 1'b1);
  endtask

  task automatic queue_seq_wrap();
    queue_fragment('{8'h80, 8'h00, 8'h04}, 1'b1);
    for (int i = 1; i <= 130; i++) queue_fragment('{8'(i & 8'h7F)}, 1'b1);
    queue_fragment('{8'(131 & 8'h7F), 8'h3C, 8'hC3, 8'h0F, 8'hF0}, 1'b1);
    queue_read(10'd3);
  endtask

  // --------------------------------------------------------------------------
  // Driver: drains the pending queue onto in_ch with random idle bursts
  // --------------------------------------------------------------------------
  frgr_pkg::in_item_t  drv_item;
  frgr_pkg::out_item_t drv_rsp;
  int                  send_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap    = 0;
    end else begin
      // predict at the transfer
      if (in_ch.valid && in_ch.ready) begin
        if (reassemble(drv_item, drv_rsp)) expected_results.push_back(drv_rsp);
        items_done++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0 || pending_items.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_ch.valid <= 1'b0;
        end else begin
          drv_item = pending_items.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.action     <= drv_item.action;
          in_ch.data_byte  <= drv_item.data_byte;
          in_ch.frag_first <= drv_item.frag_first;
          in_ch.frag_last  <= drv_item.frag_last;
          in_ch.read_index <= drv_item.read_index;
          if (pending_items.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0)
            send_gap = $urandom_range(1, 10);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure, one long hold-off, result checks
  // --------------------------------------------------------------------------
  frgr_pkg::out_item_t want;
  int                  recv_gap;
  int                  hold_left;
  bit                  hold_done;

  function automatic void check_field(string name, int unsigned exp_val,
                                      int unsigned got_val);
    if (exp_val != got_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap  = 0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result transfer with no prediction outstanding");
          err_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.res.status, out_ch.status);
          check_field("complete", want.res.complete, out_ch.complete);
          check_field("message_length", want.res.message_length,
                      out_ch.message_length);
          check_field("received_length", want.res.received_length,
                      out_ch.received_length);
          check_field("next_seq", want.res.next_seq, out_ch.next_seq);
          check_field("read_data", want.read_data, out_ch.read_data);
          if (want.res.status != frgr_pkg::ST_OK) error_statuses++;
          if (want.read_data != 8'h00) data_reads++;
        end
      end
      // fill the block: hold off while the driver keeps offering
      if (!hold_done && items_done >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (pending_items.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0)
          recv_gap = $urandom_range(1, 10);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: no transfer on either channel for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.action     = frgr_pkg::ACT_NOP;
    in_ch.data_byte  = '0;
    in_ch.frag_first = 1'b0;
    in_ch.frag_last  = 1'b0;
    in_ch.read_index = '0;
    out_ch.ready     = 1'b0;
    stim_count       = 0;
    items_done       = 0;
    results_seen     = 0;
    error_statuses   = 0;
    data_reads       = 0;
    err_count        = 0;
    stall_cycles     = 0;
    hold_done        = 1'b0;
    clear_reassembly();

    // Directed corner cases
    queue_read(10'd0);                                   // nothing received yet
    queue_item(frgr_pkg::ACT_FRAG, 8'h12, 1'b0, 1'b0, 10'd0);    // stray byte
    queue_item(frgr_pkg::ACT_FRAG, 8'hED, 1'b0, 1'b1, 10'h3FF);  // stray last
    queue_fragment('{8'h01}, 1'b1);                      // CONT with no message
    queue_fragment('{8'h80}, 1'b1);                      // INIT, command only
    queue_fragment('{8'hFF, 8'h00}, 1'b1);               // INIT cut in length
    queue_fragment('{8'h80, 8'h04, 8'h01}, 1'b1);        // one over the limit
    queue_fragment('{8'h80, 8'h00, 8'h00}, 1'b1);        // empty message
    queue_read(10'd0);                                   // past the end
    queue_fragment('{8'hC0, 8'h04, 8'h00}, 1'b1);        // largest length
    queue_read(10'h3FF);                                 // still incomplete
    queue_fragment('{8'h80, 8'h00}, 1'b0);               // abandoned INIT
    queue_fragment('{8'h81, 8'h00, 8'h02, 8'hFF}, 1'b1);
    queue_fragment('{8'h05, 8'h11}, 1'b1);               // wrong sequence
    queue_fragment('{8'h01, 8'h00, 8'h55}, 1'b1);        // overrun is dropped
    queue_read(10'd0);
    queue_read(10'd1);
    queue_clear();
    queue_item(frgr_pkg::ACT_NOP, 8'hFF, 1'b1, 1'b1, 10'h3FF);

    // Random part
    queue_seq_wrap();
    while (stim_count < STIM_ITEMS) begin
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        queue_message($urandom_range(0, 40), $urandom_range(1, 12), 1'b0);
      end else if (pick < 65) begin
        queue_message($urandom_range(100, MSG_MAX), 16, 1'b1);
      end else if (pick < 75) begin
        queue_noise($urandom_range(1, 4));
      end else if (pick < 82) begin
        queue_clear();
        queue_message($urandom_range(0, 24), $urandom_range(1, 8), 1'b0);
      end else if (pick < 92) begin
        queue_broken();
      end else begin
        queue_read(10'($urandom_range(0, 1023)));
      end
    end
    total_items = pending_items.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (items_done < total_items || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d transfers (reads, resets, fragment bytes incl. faults).",
             items_done);
    $display("Checked %0d results: %0d with error status, %0d returning data.",
             results_seen, error_statuses, data_reads);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/frgr_pkg.sv
src/frgr_in_if.sv
src/frgr_out_if.sv
src/frgr_store.sv
src/frgr_ctrl.sv
src/frgr_out.sv
src/fragment_reassembler.sv
bench/testbench.sv
